>>> hw/rtl/sti_pkg.sv
package sti_pkg;

   // width of one packed point on the channel
   localparam int unsigned FIELD_W = 48;

   // register stages from acceptance to result
   localparam int unsigned NUM_STG = 8;

   localparam int unsigned NUM_PTS    = 5;
   localparam int unsigned NUM_ORIENT = 8;
   localparam int unsigned NUM_PAIRS  = NUM_ORIENT / 2;

   // point codes
   localparam logic [2:0] PT_A = 3'd0;
   localparam logic [2:0] PT_B = 3'd1;
   localparam logic [2:0] PT_C = 3'd2;
   localparam logic [2:0] PT_P = 3'd3;
   localparam logic [2:0] PT_Q = 3'd4;

   // operands of each orientation, consecutive entries form a pair
   localparam logic [2:0] ORIENT_SEL [NUM_ORIENT][4] = '{
      '{PT_A, PT_B, PT_C, PT_P},
      '{PT_A, PT_B, PT_C, PT_Q},
      '{PT_P, PT_Q, PT_A, PT_B},
      '{PT_P, PT_Q, PT_A, PT_C},
      '{PT_P, PT_Q, PT_B, PT_A},
      '{PT_P, PT_Q, PT_B, PT_C},
      '{PT_P, PT_Q, PT_C, PT_A},
      '{PT_P, PT_Q, PT_C, PT_B}
   };

   typedef struct packed {
      logic neg;
      logic zero;
   } orient_sign_type;

   // load enables of the orientation pipeline stages
   typedef struct packed {
      logic diff;
      logic prod;
      logic minor;
      logic part;
      logic term;
      logic sgn;
   } orient_en_type;

endpackage

>>> hw/rtl/sti_if.sv
interface sti_req_if import sti_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] corner_a;
   logic [FIELD_W-1:0] corner_b;
   logic [FIELD_W-1:0] corner_c;
   logic [FIELD_W-1:0] seg_start;
   logic [FIELD_W-1:0] seg_end;

   modport source (
      output valid, corner_a, corner_b, corner_c, seg_start, seg_end,
      input  ready
   );
   modport sink (
      input  valid, corner_a, corner_b, corner_c, seg_start, seg_end,
      output ready
   );
endinterface

interface sti_rsp_if ();
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

>>> hw/rtl/sti_orient.sv
module sti_orient import sti_pkg::*; #(
   parameter int unsigned COORD_BITS = 16
) (
   input  logic                         clock,
   input  orient_en_type                en,
   input  logic signed [COORD_BITS-1:0] pt_a [3],
   input  logic signed [COORD_BITS-1:0] pt_b [3],
   input  logic signed [COORD_BITS-1:0] pt_c [3],
   input  logic signed [COORD_BITS-1:0] pt_d [3],
   output orient_sign_type              sgn
);

   localparam int unsigned D_W   = COORD_BITS + 1;
   localparam int unsigned P_W   = 2 * D_W;
   localparam int unsigned M_W   = P_W + 1;
   localparam int unsigned L_W   = D_W + 1;
   localparam int unsigned HI_W  = 2 * D_W;
   localparam int unsigned LO_W  = D_W + L_W + 1;
   localparam int unsigned DET_W = 3 * D_W + 3;

   logic signed [COORD_BITS-1:0] row [3][3];
   logic signed [D_W-1:0]        diff_in [3][3];
   logic signed [D_W-1:0]        diff_ff [3][3];
   logic signed [P_W-1:0]        prod_in [6];
   logic signed [P_W-1:0]        prod_ff [6];
   logic signed [D_W-1:0]        arow_p_ff [3];
   logic signed [M_W-1:0]        minor_in [3];
   logic signed [M_W-1:0]        minor_ff [3];
   logic signed [D_W-1:0]        arow_m_ff [3];
   logic signed [HI_W-1:0]       hi_in [3];
   logic signed [HI_W-1:0]       hi_ff [3];
   logic signed [LO_W-1:0]       lo_in [3];
   logic signed [LO_W-1:0]       lo_ff [3];
   logic signed [DET_W-1:0]      term_in [3];
   logic signed [DET_W-1:0]      term_ff [3];
   logic signed [DET_W-1:0]      det;
   orient_sign_type              sgn_in;
   orient_sign_type              sgn_ff;

   assign row[0] = pt_a;
   assign row[1] = pt_b;
   assign row[2] = pt_c;

   // rows relative to the fourth point
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            diff_in[r][k] = D_W'(row[r][k]) - D_W'(pt_d[k]);
         end
      end
   end

   // products for the 2x2 minors
   always_comb begin
      prod_in[0] = diff_ff[1][1] * diff_ff[2][2];
      prod_in[1] = diff_ff[1][2] * diff_ff[2][1];
      prod_in[2] = diff_ff[1][0] * diff_ff[2][2];
      prod_in[3] = diff_ff[1][2] * diff_ff[2][0];
      prod_in[4] = diff_ff[1][0] * diff_ff[2][1];
      prod_in[5] = diff_ff[1][1] * diff_ff[2][0];
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         minor_in[k] = M_W'(prod_ff[2*k]) - M_W'(prod_ff[2*k+1]);
      end
   end

   // minor split into signed upper and unsigned lower halves
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hi_in[k] = arow_m_ff[k] * $signed(minor_ff[k][M_W-1:L_W]);
         lo_in[k] = arow_m_ff[k] * $signed({1'b0, minor_ff[k][L_W-1:0]});
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term_in[k] = (DET_W'(hi_ff[k]) <<< L_W) + DET_W'(lo_ff[k]);
      end
   end

   always_comb begin
      det         = term_ff[0] - term_ff[1] + term_ff[2];
      sgn_in.neg  = det[DET_W-1];
      sgn_in.zero = (det == '0);
   end

   always_ff @(posedge clock) begin
      if (en.diff) begin
         diff_ff <= diff_in;
      end
      if (en.prod) begin
         prod_ff   <= prod_in;
         arow_p_ff <= diff_ff[0];
      end
      if (en.minor) begin
         minor_ff  <= minor_in;
         arow_m_ff <= arow_p_ff;
      end
      if (en.part) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
      if (en.term) begin
         term_ff <= term_in;
      end
      if (en.sgn) begin
         sgn_ff <= sgn_in;
      end
   end

   assign sgn = sgn_ff;

endmodule

>>> hw/rtl/segment_triangle_intersect_top.sv
// channel | dir | signals                                              | transaction
// req_if  | in  | valid, ready, corner_a, corner_b, corner_c,          | one query
//         |     | seg_start, seg_end                                   |
// rsp_if  | out | valid, ready, hit                                    | one result
//
// one transaction per cycle sustained while rsp_if accepts results; result valid once the query
// has passed through an 8-stage pipeline (input, differences, products, minors, split
// products, terms, signs, hit)
// synchronous reset clears only the stage valid bits
// each stage loads when it is empty or the next stage loads, so bubbles collapse and
// a stalled rsp_if holds its result while earlier stages keep filling

module segment_triangle_intersect_top import sti_pkg::*; #(
   parameter int unsigned COORD_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   sti_req_if.sink    req_if,
   sti_rsp_if.source  rsp_if
);

   localparam int unsigned PACK_W = 3 * COORD_BITS;

   logic [NUM_STG-1:0]           vld_in;
   logic [NUM_STG-1:0]           vld_ff;
   logic [NUM_STG-1:0]           en;
   orient_en_type                oen;
   logic [FIELD_W-1:0]           fld [NUM_PTS];
   logic [PACK_W+FIELD_W-1:0]    ext [NUM_PTS];
   logic signed [COORD_BITS-1:0] pt_in [NUM_PTS][3];
   logic signed [COORD_BITS-1:0] pt_ff [NUM_PTS][3];
   orient_sign_type              osgn [NUM_ORIENT];
   logic [NUM_PAIRS-1:0]         pair_ok;
   logic                         hit_in;
   logic                         hit_ff;

   // stage load enables
   always_comb begin
      en[NUM_STG-1] = !vld_ff[NUM_STG-1] || rsp_if.ready;
      for (int i = NUM_STG - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_comb begin
      vld_in[0] = en[0] ? req_if.valid : vld_ff[0];
      for (int i = 1; i < NUM_STG; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_if.ready = en[0];

   // unpack coordinates, bits beyond the field read as zero
   assign fld[PT_A] = req_if.corner_a;
   assign fld[PT_B] = req_if.corner_b;
   assign fld[PT_C] = req_if.corner_c;
   assign fld[PT_P] = req_if.seg_start;
   assign fld[PT_Q] = req_if.seg_end;

   always_comb begin
      for (int p = 0; p < NUM_PTS; p++) begin
         ext[p] = {{PACK_W{1'b0}}, fld[p]};
         for (int k = 0; k < 3; k++) begin
            pt_in[p][k] = $signed(ext[p][k*COORD_BITS +: COORD_BITS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pt_ff <= pt_in;
      end
   end

   assign oen.diff  = en[1];
   assign oen.prod  = en[2];
   assign oen.minor = en[3];
   assign oen.part  = en[4];
   assign oen.term  = en[5];
   assign oen.sgn   = en[6];

   for (genvar g = 0; g < NUM_ORIENT; g++) begin : g_orient
      sti_orient #(
         .COORD_BITS (COORD_BITS)
      ) u_orient (
         .clock (clock),
         .en    (oen),
         .pt_a  (pt_ff[ORIENT_SEL[g][0]]),
         .pt_b  (pt_ff[ORIENT_SEL[g][1]]),
         .pt_c  (pt_ff[ORIENT_SEL[g][2]]),
         .pt_d  (pt_ff[ORIENT_SEL[g][3]]),
         .sgn   (osgn[g])
      );
   end

   // strictly opposite signs in every pair
   always_comb begin
      for (int j = 0; j < NUM_PAIRS; j++) begin
         pair_ok[j] = !osgn[2*j].zero && !osgn[2*j+1].zero
                   && (osgn[2*j].neg != osgn[2*j+1].neg);
      end
      hit_in = &pair_ok;
   end

   always_ff @(posedge clock) begin
      if (en[NUM_STG-1]) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_if.valid = vld_ff[NUM_STG-1];
   assign rsp_if.hit   = hit_ff;

endmodule

>>> dv/segment_hit_checker.sv
module segment_hit_checker import sti_pkg::*; #(
   parameter int unsigned COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   sti_req_if          req_mon,
   sti_rsp_if          rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] z;
   } point_type;

   logic        expected_hits [$];
   logic        expected_hit;
   int unsigned result_index;

   function automatic logic [63:0] coord_ext(logic [FIELD_W-1:0] word, int unsigned idx);
      logic [63:0]           wide;
      logic [COORD_BITS-1:0] v;
      wide = 64'(word);
      v = wide[idx*COORD_BITS +: COORD_BITS];
      return {{(64-COORD_BITS){v[COORD_BITS-1]}}, v};
   endfunction

   function automatic point_type unpack_point(logic [FIELD_W-1:0] word);
      point_type p;
      p.x = coord_ext(word, 0);
      p.y = coord_ext(word, 1);
      p.z = coord_ext(word, 2);
      return p;
   endfunction

   // sign of det[[a-d],[b-d],[c-d]] taken modulo 2^64
   function automatic orient_sign_type orient(point_type a, point_type b, point_type c,
                                              point_type d);
      logic [63:0]     ax, ay, az, bx, by, bz, cx, cy, cz, det;
      orient_sign_type s;
      ax = a.x - d.x;
      ay = a.y - d.y;
      az = a.z - d.z;
      bx = b.x - d.x;
      by = b.y - d.y;
      bz = b.z - d.z;
      cx = c.x - d.x;
      cy = c.y - d.y;
      cz = c.z - d.z;
      det = ax * (by * cz - bz * cy) - ay * (bx * cz - bz * cx) + az * (bx * cy - by * cx);
      s.zero = (det == 64'd0);
      s.neg  = det[63];
      return s;
   endfunction

   function automatic logic strictly_opposite(orient_sign_type s0, orient_sign_type s1);
      return !s0.zero && !s1.zero && (s0.neg != s1.neg);
   endfunction

   function automatic logic predict_crossing(logic [FIELD_W-1:0] wa, logic [FIELD_W-1:0] wb,
                                             logic [FIELD_W-1:0] wc, logic [FIELD_W-1:0] wp,
                                             logic [FIELD_W-1:0] wq);
      point_type a, b, c, p, q;
      logic      crossing;
      a = unpack_point(wa);
      b = unpack_point(wb);
      c = unpack_point(wc);
      p = unpack_point(wp);
      q = unpack_point(wq);
      crossing = strictly_opposite(orient(a, b, c, p), orient(a, b, c, q));
      crossing &= strictly_opposite(orient(p, q, a, b), orient(p, q, a, c));
      crossing &= strictly_opposite(orient(p, q, b, a), orient(p, q, b, c));
      crossing &= strictly_opposite(orient(p, q, c, a), orient(p, q, c, b));
      return crossing;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      result_index   = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            expected_hits.push_back(predict_crossing(req_mon.corner_a, req_mon.corner_b,
                                                     req_mon.corner_c, req_mon.seg_start,
                                                     req_mon.seg_end));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_hits.size() == 0) begin
               report_mismatch($sformatf("result %0d hit=%b with no query outstanding",
                                         result_index, rsp_mon.hit));
            end else begin
               expected_hit = expected_hits.pop_front();
               if (rsp_mon.hit !== expected_hit) begin
                  report_mismatch($sformatf("result %0d hit=%b, expected %b",
                                            result_index, rsp_mon.hit, expected_hit));
               end
            end
            result_index++;
         end
         outstanding <= expected_hits.size();
      end
   end

endmodule

>>> dv/tb_segment_triangle_intersect_top.sv
module tb_segment_triangle_intersect_top;
   import sti_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COORD_BITS     = 16;
   localparam int          COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
   localparam int          COORD_MIN      = -(1 << (COORD_BITS - 1));
   localparam int unsigned NUM_RANDOM     = 800;
   localparam int unsigned LONG_HOLD      = 150;
   localparam int unsigned HOLD_START     = 300;
   localparam int unsigned DRAIN_CYCLES   = 2 * NUM_STG;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned NUM_DIRECTED   = 14;

   localparam int DIRECTED_QUERIES [NUM_DIRECTED][NUM_PTS][3] = '{
      '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{10, 10, -50}, '{10, 10, 50}},
      '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{10, 10, 50}, '{10, 10, -50}},
      '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{10, 10, 0}, '{10, 10, 50}},
      '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{50, 0, -5}, '{50, 0, 5}},
      '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{0, 0, -5}, '{0, 0, 5}},
      '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{200, 200, -5}, '{200, 200, 5}},
      '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{10, 10, 5}, '{10, 10, 50}},
      '{'{0, 0, 0}, '{10, 10, 10}, '{20, 20, 20}, '{5, 0, -5}, '{0, 5, 5}},
      '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{10, 10, 5}, '{10, 10, 5}},
      '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{-10, 10, 0}, '{50, 10, 0}},
      '{'{COORD_MIN, COORD_MIN, 0}, '{COORD_MAX, COORD_MIN, 0}, '{0, COORD_MAX, 0},
        '{0, 0, COORD_MIN}, '{0, 0, COORD_MAX}},
      '{'{COORD_MIN, COORD_MIN, COORD_MIN}, '{COORD_MAX, COORD_MIN, COORD_MAX},
        '{COORD_MIN, COORD_MAX, COORD_MAX}, '{COORD_MAX, COORD_MAX, COORD_MIN},
        '{COORD_MIN, COORD_MIN, COORD_MAX}},
      '{'{0, COORD_MIN, COORD_MIN}, '{0, COORD_MAX, COORD_MIN}, '{0, 0, COORD_MAX},
        '{COORD_MIN, 0, 0}, '{COORD_MAX, 0, 0}},
      '{'{COORD_MAX, COORD_MAX, COORD_MAX}, '{COORD_MAX, COORD_MAX, COORD_MAX},
        '{COORD_MAX, COORD_MAX, COORD_MAX}, '{COORD_MIN, COORD_MIN, COORD_MIN},
        '{COORD_MAX, COORD_MAX, COORD_MAX}}
   };

   localparam logic [FIELD_W-1:0] RAW_PATTERNS [4] = '{
      '0, '1, {(FIELD_W/4){4'hA}}, {(FIELD_W/4){4'h5}}
   };

   localparam int EXTREME_VALS [6] = '{COORD_MIN, COORD_MIN + 1, -1, 0, 1, COORD_MAX};

   logic clock = 1'b0;
   logic reset = 1'b1;

   sti_req_if req_if ();
   sti_rsp_if rsp_if ();

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned idle_cycles = 0;

   logic [FIELD_W-1:0] query [NUM_PTS];
   int                 coord [NUM_PTS][3];

   segment_triangle_intersect_top #(.COORD_BITS(COORD_BITS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   segment_hit_checker #(.COORD_BITS(COORD_BITS)) hit_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [FIELD_W-1:0] pack_point(int x, int y, int z);
      logic [31:0] ux, uy, uz;
      ux = x;
      uy = y;
      uz = z;
      return {uz[COORD_BITS-1:0], uy[COORD_BITS-1:0], ux[COORD_BITS-1:0]};
   endfunction

   function automatic int rand_coord(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic pack_coords();
      for (int i = 0; i < NUM_PTS; i++) begin
         query[i] = pack_point(coord[i][0], coord[i][1], coord[i][2]);
      end
   endtask

   task automatic send_query();
      req_if.valid     <= 1'b1;
      req_if.corner_a  <= query[PT_A];
      req_if.corner_b  <= query[PT_B];
      req_if.corner_c  <= query[PT_C];
      req_if.seg_start <= query[PT_P];
      req_if.seg_end   <= query[PT_Q];
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic make_random_query();
      int unsigned mode, k, src, dst, idx;
      int          w [3];
      int          x [3];
      int          d [3];
      logic [63:0] raw;
      mode = $urandom_range(0, 9);
      case (mode)
         0, 1, 2, 3, 8: begin
            // segment through a weighted point of the triangle, on an edge or corner for 8
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  coord[i][j] = rand_coord(8000);
               end
               w[i] = $urandom_range(1, 15);
            end
            if (mode == 8) begin
               idx = $urandom_range(0, 2);
               w[idx] = 0;
               if ($urandom_range(0, 1) == 1) begin
                  w[(idx + 1) % 3] = 0;
               end
            end
            k = $urandom_range(1, 2);
            for (int j = 0; j < 3; j++) begin
               x[j] = (w[0] * coord[0][j] + w[1] * coord[1][j] + w[2] * coord[2][j])
                      / (w[0] + w[1] + w[2]);
               d[j] = rand_coord(8000);
               coord[PT_P][j] = x[j] + d[j];
               coord[PT_Q][j] = x[j] - int'(k) * d[j];
            end
            pack_coords();
         end
         4, 5: begin
            for (int i = 0; i < NUM_PTS; i++) begin
               raw = {$urandom, $urandom};
               query[i] = raw[FIELD_W-1:0];
            end
         end
         6: begin
            for (int i = 0; i < NUM_PTS; i++) begin
               for (int j = 0; j < 3; j++) begin
                  coord[i][j] = rand_coord(3);
               end
            end
            pack_coords();
         end
         7: begin
            for (int i = 0; i < NUM_PTS; i++) begin
               for (int j = 0; j < 3; j++) begin
                  coord[i][j] = EXTREME_VALS[$urandom_range(0, 5)];
               end
            end
            pack_coords();
         end
         default: begin
            // repeated point makes the triangle or the segment degenerate, or puts a segment end on a corner
            for (int i = 0; i < NUM_PTS; i++) begin
               for (int j = 0; j < 3; j++) begin
                  coord[i][j] = rand_coord(100);
               end
            end
            src = $urandom_range(0, NUM_PTS - 1);
            dst = (src + $urandom_range(1, NUM_PTS - 1)) % NUM_PTS;
            coord[dst] = coord[src];
            pack_coords();
         end
      endcase
   endtask

   initial begin
      int unsigned burst_left;
      int unsigned gap;
      req_if.valid     <= 1'b0;
      req_if.corner_a  <= '0;
      req_if.corner_b  <= '0;
      req_if.corner_c  <= '0;
      req_if.seg_start <= '0;
      req_if.seg_end   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < NUM_DIRECTED; n++) begin
         coord = DIRECTED_QUERIES[n];
         pack_coords();
         send_query();
      end
      for (int r = 0; r < 4; r++) begin
         for (int i = 0; i < NUM_PTS; i++) begin
            query[i] = RAW_PATTERNS[(r + i) % 4];
         end
         send_query();
      end

      burst_left = 0;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
               req_if.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         make_random_query();
         send_query();
         burst_left--;
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // result side stalls on its own pattern, with one long hold-off to back up the pipe
   initial begin
      int unsigned rx_cycles;
      int unsigned span_left;
      int unsigned mode;
      logic        long_hold_done;
      rx_cycles      = 0;
      span_left      = 0;
      mode           = 0;
      long_hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            rx_cycles++;
            if (!long_hold_done && rx_cycles >= HOLD_START) begin
               long_hold_done = 1'b1;
               rsp_if.ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end else begin
               if (span_left == 0) begin
                  mode      = $urandom_range(0, 3);
                  span_left = $urandom_range(5, 60);
               end
               span_left--;
               case (mode)
                  0:       rsp_if.ready <= 1'b1;
                  1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
                  2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> filelist.f
hw/rtl/sti_pkg.sv
hw/rtl/sti_if.sv
hw/rtl/sti_orient.sv
hw/rtl/segment_triangle_intersect_top.sv
dv/segment_hit_checker.sv
dv/tb_segment_triangle_intersect_top.sv
